/* rtl/cbfa_pkg.sv */
`default_nettype none

package cbfa_pkg;

  localparam int SizeW = 20;
  localparam int IdxW  = 8;
  localparam int StW   = 2;

  typedef enum logic [StW-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_INVAL = 2'd2,
    ST_ZERO  = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic    latch;
    logic    hdr_rd;
    logic    fchk_load;
    logic    scan_init;
    logic    scan_en;
    logic    wr_taken;
    logic    taken_val;
    logic    wr_hdr;
    logic    mark;
    logic    pos_inc;
    logic    rem_dec;
    logic    res_load;
    status_e res_status;
    logic    res_chunk;
    logic    out_load;
  } cbfa_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_free;
    logic size_zero;
    logic size_big;
    logic free_null;
    logic free_bad;
    logic hdr_set;
    logic found;
    logic exhausted;
    logic fclr_end;
    logic rem_one;
    logic pos_last;
    logic out_free;
  } cbfa_sts_t;

endpackage

`default_nettype wire

/* rtl/cbfa_ctrl.sv */
`default_nettype none

module cbfa_ctrl import cbfa_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  input  cbfa_sts_t  sts_i,
  output cbfa_cmd_t  cmd_o,
  output logic       idle_o
);

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_FCHK   = 8'b0000_1000,
    S_FCLR   = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_MARK   = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.wr_taken = 1'b1;
        cmd_o.wr_hdr   = 1'b1;
        cmd_o.pos_inc  = 1'b1;
        if (sts_i.pos_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!sts_i.is_free) begin
          if (sts_i.size_zero) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_ZERO;
            state_d          = S_DONE;
          end else if (sts_i.size_big) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_NOMEM;
            state_d          = S_DONE;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN;
          end
        end else if (sts_i.free_null) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else if (sts_i.free_bad) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INVAL;
          state_d          = S_DONE;
        end else begin
          cmd_o.hdr_rd = 1'b1;
          state_d      = S_FCHK;
        end
      end
      S_FCHK: begin
        if (!sts_i.hdr_set) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_INVAL;
          state_d          = S_DONE;
        end else begin
          cmd_o.fchk_load = 1'b1;
          state_d         = S_FCLR;
        end
      end
      S_FCLR: begin
        if (sts_i.fclr_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          state_d          = S_DONE;
        end else begin
          cmd_o.wr_taken = 1'b1;
          cmd_o.pos_inc  = 1'b1;
          cmd_o.rem_dec  = 1'b1;
        end
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.found) begin
          state_d = S_MARK;
        end else if (sts_i.exhausted) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_NOMEM;
          state_d          = S_DONE;
        end
      end
      S_MARK: begin
        cmd_o.wr_taken  = 1'b1;
        cmd_o.taken_val = 1'b1;
        cmd_o.wr_hdr    = 1'b1;
        cmd_o.mark      = 1'b1;
        cmd_o.pos_inc   = 1'b1;
        cmd_o.rem_dec   = 1'b1;
        if (sts_i.rem_one) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_OK;
          cmd_o.res_chunk  = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  assign idle_o = (state_q == S_IDLE);

endmodule

`default_nettype wire

/* rtl/cbfa_dpath.sv */
`default_nettype none

module cbfa_dpath import cbfa_pkg::*; #(
  parameter int NUM_CHUNKS  = 256,
  parameter int CHUNK_BYTES = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              opcode_i,
  input  wire  [SizeW-1:0] size_bytes_i,
  input  wire  [IdxW-1:0]  chunk_index_i,
  input  wire              null_pointer_i,
  input  cbfa_cmd_t        cmd_i,
  output cbfa_sts_t        sts_o,
  input  wire              out_stall_i,
  output logic             out_valid_o,
  output logic [StW-1:0]   status_o,
  output logic [IdxW-1:0]  data_chunk_o
);

  localparam int AW       = $clog2(NUM_CHUNKS);
  localparam int PW       = AW + 1;
  localparam int CW       = $clog2(NUM_CHUNKS + 1);
  localparam int AccW     = $clog2((1 << SizeW) + CHUNK_BYTES);
  localparam int MaxBytes = (NUM_CHUNKS - 1) * CHUNK_BYTES;

  localparam logic [PW-1:0]   PosEnd  = PW'(NUM_CHUNKS);
  localparam logic [PW-1:0]   PosLast = PW'(NUM_CHUNKS - 1);
  localparam logic [AccW-1:0] AccStep = AccW'(CHUNK_BYTES);

  // latched item
  logic             op_q;
  logic [SizeW-1:0] size_q;
  logic [IdxW-1:0]  idx_q;
  logic             null_q;

  // chunk state
  logic          taken_mem [NUM_CHUNKS];
  logic          hdr_mem   [NUM_CHUNKS];
  logic [CW-1:0] cnt_mem   [NUM_CHUNKS];

  logic          tk_q;
  logic          hdr_rd_q;
  logic [CW-1:0] cnt_rd_q;

  // walk pointer and remaining count
  logic [PW-1:0] pos_q;
  logic [CW-1:0] rem_q;

  // search
  logic [PW-1:0]   rd_ptr_q;
  logic            rv_q;
  logic [AW-1:0]   ra_q;
  logic [CW-1:0]   run_len_q;
  logic [AccW-1:0] acc_q;
  logic [AW-1:0]   head_q;

  // result and output
  status_e         res_status_q;
  logic [IdxW-1:0] res_chunk_q;
  logic            out_valid_q;
  logic [StW-1:0]  out_status_q;
  logic [IdxW-1:0] out_chunk_q;

  logic [IdxW-1:0] idx_m1;
  logic [AW-1:0]   hdr_addr;
  logic [AW-1:0]   waddr;
  logic            at_head;
  logic            scan_rd;
  logic [AccW-1:0] acc_next;
  logic            found;
  logic [PW-1:0]   head_plus;

  assign idx_m1    = idx_q - IdxW'(1);
  assign hdr_addr  = AW'(idx_m1);
  assign waddr     = pos_q[AW-1:0];
  assign at_head   = (waddr == head_q);
  assign scan_rd   = cmd_i.scan_en && (rd_ptr_q != PosEnd);
  assign acc_next  = acc_q + AccStep;
  assign found     = cmd_i.scan_en && rv_q && !tk_q && (run_len_q != '0)
                     && (acc_next >= AccW'(size_q));
  assign head_plus = {1'b0, head_q} + PW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= opcode_i;
      size_q <= size_bytes_i;
      idx_q  <= chunk_index_i;
      null_q <= null_pointer_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_taken) begin
      taken_mem[waddr] <= cmd_i.taken_val;
    end
    if (scan_rd) begin
      tk_q <= taken_mem[rd_ptr_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_hdr) begin
      hdr_mem[waddr] <= cmd_i.mark && at_head;
    end
    if (cmd_i.hdr_rd) begin
      hdr_rd_q <= hdr_mem[hdr_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mark && at_head) begin
      cnt_mem[waddr] <= rem_q;
    end
    if (cmd_i.hdr_rd) begin
      cnt_rd_q <= cnt_mem[hdr_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rem_q <= '0;
    end else begin
      if (cmd_i.fchk_load) begin
        pos_q <= {1'b0, hdr_addr};
        rem_q <= cnt_rd_q;
      end else if (found) begin
        pos_q <= {1'b0, head_q};
        rem_q <= run_len_q + CW'(1);
      end else begin
        if (cmd_i.pos_inc) begin
          pos_q <= pos_q + PW'(1);
        end
        if (cmd_i.rem_dec) begin
          rem_q <= rem_q - CW'(1);
        end
      end
    end
  end

  // first-fit walk, one taken bit per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      rv_q      <= 1'b0;
      run_len_q <= '0;
    end else if (cmd_i.scan_init) begin
      rd_ptr_q  <= '0;
      rv_q      <= 1'b0;
      run_len_q <= '0;
    end else if (cmd_i.scan_en) begin
      rv_q <= scan_rd;
      if (scan_rd) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (rv_q && !found) begin
        if (tk_q) begin
          run_len_q <= '0;
        end else begin
          run_len_q <= run_len_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (scan_rd) begin
      ra_q <= rd_ptr_q[AW-1:0];
    end
    if (cmd_i.scan_en && rv_q && !tk_q && !found) begin
      if (run_len_q == '0) begin
        head_q <= ra_q;
        acc_q  <= '0;
      end else begin
        acc_q <= acc_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_chunk_q  <= cmd_i.res_chunk ? IdxW'(head_plus) : '0;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_chunk_q  <= res_chunk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.is_free   = op_q;
    sts_o.size_zero = (size_q == '0);
    sts_o.size_big  = (32'(size_q) > MaxBytes);
    sts_o.free_null = null_q;
    sts_o.free_bad  = (idx_q == '0) || (32'(idx_q) > NUM_CHUNKS);
    sts_o.hdr_set   = hdr_rd_q;
    sts_o.found     = found;
    sts_o.exhausted = cmd_i.scan_en && !rv_q && (rd_ptr_q == PosEnd);
    sts_o.fclr_end  = (rem_q == '0) || (pos_q == PosEnd);
    sts_o.rem_one   = (rem_q == CW'(1));
    sts_o.pos_last  = (pos_q == PosLast);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign data_chunk_o = out_chunk_q;

endmodule

`default_nettype wire

/* rtl/chunk_bitmap_first_fit_allocator_core.sv */
// channel  direction  handshake              payload
// in       input      in_valid_i/in_stall_o    opcode_i, size_bytes_i, chunk_index_i,
//                                              null_pointer_i
// out      output     out_valid_o/out_stall_i  status_o, data_chunk_o
//
// a clearing pass after reset wipes the taken bit and mark of every chunk, in_stall_o high
// zero size, oversize, null free, free of chunk 0 or above NUM_CHUNKS end in DECODE;
// free without header ends in FCHK; free: FCLR clears the taken bit of each chunk released
// allocate: SCAN finds the first free run that fits, MARK takes it, ST_NOMEM if none fits,
//   the taken-bit read port walks one chunk per cycle
// one item at a time; a new item is taken while the last result waits in the output register
`default_nettype none

module chunk_bitmap_first_fit_allocator_core import cbfa_pkg::*; #(
  parameter int NUM_CHUNKS  = 256,
  parameter int CHUNK_BYTES = 64
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire              opcode_i,
  input  wire  [SizeW-1:0] size_bytes_i,
  input  wire  [IdxW-1:0]  chunk_index_i,
  input  wire              null_pointer_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic [StW-1:0]   status_o,
  output logic [IdxW-1:0]  data_chunk_o
);

  cbfa_cmd_t cmd;
  cbfa_sts_t sts;
  logic      idle;

  cbfa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .idle_o     (idle)
  );

  cbfa_dpath #(
    .NUM_CHUNKS  (NUM_CHUNKS),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .opcode_i       (opcode_i),
    .size_bytes_i   (size_bytes_i),
    .chunk_index_i  (chunk_index_i),
    .null_pointer_i (null_pointer_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .status_o       (status_o),
    .data_chunk_o   (data_chunk_o)
  );

  assign in_stall_o = !idle;

  a_busy_after_transfer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while previous item in work");

  a_fail_no_chunk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_OK) |-> (data_chunk_o == '0))
    else $error("failed request returned a chunk");

  a_found_xor_exhausted : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.found |-> !sts.exhausted)
    else $error("search found and exhausted at once");

  a_result_waits : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten");

endmodule

`default_nettype wire
